// ===== design/rpcd_pkg.sv =====
// Shared constants, types and colour-correction functions for the pixel chain driver.
package rpcd_pkg;

	localparam int NUM_PIXELS = 256;
	localparam int PIX_AW     = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
	localparam int CNT_W      = $clog2(NUM_PIXELS + 1);
	localparam int TIMER_W    = 20;

	localparam logic [4:0] MSB_POS = 5'd23;

	// Operation codes; the unused code behaves as a plain tick
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_LATCH = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] CFG_GAIN_RED   = 3'd0;
	localparam logic [2:0] CFG_GAIN_GREEN = 3'd1;
	localparam logic [2:0] CFG_GAIN_BLUE  = 3'd2;
	localparam logic [2:0] CFG_ONE_HIGH   = 3'd3;
	localparam logic [2:0] CFG_ONE_LOW    = 3'd4;
	localparam logic [2:0] CFG_ZERO_HIGH  = 3'd5;
	localparam logic [2:0] CFG_ZERO_LOW   = 3'd6;
	localparam logic [2:0] CFG_GAP        = 3'd7;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_HIGH = 4'b0010,
		PH_LOW  = 4'b0100,
		PH_GAP  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} gain_t;

	typedef struct packed {
		logic [15:0] one_high;
		logic [15:0] one_low;
		logic [15:0] zero_high;
		logic [15:0] zero_low;
		logic [19:0] gap;
	} timing_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} prod_t;

	typedef struct packed {
		logic              en;
		logic [PIX_AW-1:0] addr;
		logic [23:0]       colour;
		logic [23:0]       corr;
	} pix_wr_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  pixel_index;
		logic [23:0] colour;
		logic [23:0] corr;
		logic [15:0] frame_count;
	} item_t;

	// Per-channel gain products of an RRGGBB colour
	function automatic prod_t gain_mul(logic [23:0] c, gain_t g);
		prod_t p;
		p.red   = {8'd0, g.red}   * {8'd0, c[23:16]};
		p.green = {8'd0, g.green} * {8'd0, c[15:8]};
		p.blue  = {8'd0, g.blue}  * {8'd0, c[7:0]};
		return p;
	endfunction

	// Exact floor(x / 255) for products of two bytes
	function automatic logic [7:0] div255(logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
		return s[15:8];
	endfunction

	// Corrected word in line order: green, red, blue
	function automatic logic [23:0] grb_word(prod_t p);
		return {div255(p.green), div255(p.red), div255(p.blue)};
	endfunction

	function automatic logic [TIMER_W-1:0] at_least_one16(logic [15:0] v);
		return (v == 16'd0) ? TIMER_W'(1) : TIMER_W'(v);
	endfunction

	function automatic logic [TIMER_W-1:0] at_least_one20(logic [19:0] v);
		return (v == 20'd0) ? TIMER_W'(1) : TIMER_W'(v);
	endfunction

endpackage

// ===== design/rpcd_front.sv =====
// Input register and colour-correction stages in front of the serializer.
module rpcd_front import rpcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  pixel_index,
	input  logic [23:0] colour,
	input  logic [15:0] frame_count,
	input  gain_t       gains,
	output logic        item_valid,
	input  logic        item_ready,
	output item_t       item
);

	logic  v_s1, v_s2, v_s3;
	logic  rdy1, rdy2, rdy3;
	item_t item_s1, item_s2, item_s3;
	prod_t prod_s2;

	assign rdy3     = !v_s3 || item_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			item_s1.operation   <= operation;
			item_s1.pixel_index <= pixel_index;
			item_s1.colour      <= colour;
			item_s1.corr        <= 24'd0;
			item_s1.frame_count <= frame_count;
		end
		if (v_s1 && rdy2) begin
			item_s2 <= item_s1;
			prod_s2 <= gain_mul(item_s1.colour, gains);
		end
		if (v_s2 && rdy3) begin
			item_s3.operation   <= item_s2.operation;
			item_s3.pixel_index <= item_s2.pixel_index;
			item_s3.colour      <= item_s2.colour;
			item_s3.corr        <= grb_word(prod_s2);
			item_s3.frame_count <= item_s2.frame_count;
		end
	end

	assign item_valid = v_s3;
	assign item       = item_s3;

endmodule

// ===== design/rpcd_pixbuf.sv =====
// Pixel buffer with slot-zero shadow and prefetch of the next corrected word.
module rpcd_pixbuf import rpcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  gain_t            gains,
	input  logic             gain_upd,
	input  pix_wr_t          wr,
	input  logic [CNT_W-1:0] rd_ptr,
	output logic [23:0]      first_word,
	output logic [23:0]      next_word
);

	logic [23:0]           pix_mem [NUM_PIXELS];
	logic [NUM_PIXELS-1:0] filled_q;
	logic [CNT_W-1:0]      rd_nxt;
	logic [PIX_AW-1:0]     rd_addr;
	logic [23:0]           rd_q;
	logic                  rdv_q;
	prod_t                 prodn_q;
	logic [23:0]           next_q;
	logic [23:0]           pix0_q;
	prod_t                 prod0_q;
	logic [23:0]           first_q;
	logic [1:0]            gupd_q;
	logic                  wr_slot0;

	// Prefetch the slot after the one being sent
	assign rd_nxt   = rd_ptr + CNT_W'(1);
	assign rd_addr  = rd_nxt[PIX_AW-1:0];
	assign wr_slot0 = wr.en && (wr.addr == PIX_AW'(0));

	always_ff @(posedge clk) begin
		if (wr.en) pix_mem[wr.addr] <= wr.colour;
		rd_q    <= pix_mem[rd_addr];
		rdv_q   <= filled_q[rd_addr];
		prodn_q <= gain_mul(rdv_q ? rd_q : 24'd0, gains);
		next_q  <= grb_word(prodn_q);
		prod0_q <= gain_mul(pix0_q, gains);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			pix0_q   <= 24'd0;
			first_q  <= 24'd0;
			gupd_q   <= 2'b00;
		end else begin
			gupd_q <= {gupd_q[0], gain_upd};
			if (wr.en) filled_q[wr.addr] <= 1'b1;
			if (wr_slot0) begin
				pix0_q  <= wr.colour;
				first_q <= wr.corr;
			end else if (gupd_q[1]) begin
				// Gain update has passed both gupd_q stages: product of slot zero is fresh now
				first_q <= grb_word(prod0_q);
			end
		end
	end

	assign first_word = first_q;
	assign next_word  = next_q;

endmodule

// ===== design/rpcd_serial.sv =====
// Send sequencer and result register: phase timing, bit walk and frame pointer.
module rpcd_serial import rpcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	input  timing_t          timing,
	input  logic [23:0]      first_word,
	input  logic [23:0]      next_word,
	output pix_wr_t          wr,
	output logic [CNT_W-1:0] ptr,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             line_level,
	output logic             busy_res,
	output logic             ignored
);

	phase_t             phase_q, phase_a, phase_n;
	logic [TIMER_W-1:0] timer_q, timer_a, timer_n, timer_dec;
	logic [4:0]         bitpos_q, bit_a, bit_n, bit_dn;
	logic [23:0]        word_q, word_a, word_n;
	logic [CNT_W-1:0]   ptr_q, ptr_a, ptr_n, ptr_inc;
	logic [CNT_W-1:0]   cnt_q, cnt_a, cnt_n, cnt_clamp;
	logic               out_valid_q, line_level_q, busy_res_q, ignored_q;
	logic               take, fire, busy0, is_req, dropped, level, busy;
	logic               cur_bit, nxt_bit, idx_ok;

	assign take       = !out_valid_q || out_ready;
	assign item_ready = take;
	assign fire       = item_valid && take;

	assign cnt_clamp = (item.frame_count > 16'(NUM_PIXELS)) ? CNT_W'(NUM_PIXELS)
	                                                       : item.frame_count[CNT_W-1:0];
	assign idx_ok    = 32'(item.pixel_index) < NUM_PIXELS;

	always_comb begin
		phase_a = phase_q;
		timer_a = timer_q;
		bit_a   = bitpos_q;
		word_a  = word_q;
		ptr_a   = ptr_q;
		cnt_a   = cnt_q;
		busy0   = phase_q != PH_IDLE;
		is_req  = (item.operation == OP_WRITE) || (item.operation == OP_LATCH);
		dropped = is_req && busy0;

		wr.en     = 1'b0;
		wr.addr   = PIX_AW'(item.pixel_index);
		wr.colour = item.colour;
		wr.corr   = item.corr;

		if (!busy0 && item.operation == OP_WRITE && idx_ok) begin
			wr.en = fire;
		end

		if (!busy0 && item.operation == OP_LATCH) begin
			cnt_a = cnt_clamp;
			ptr_a = '0;
			if (cnt_clamp != '0) begin
				word_a  = first_word;
				bit_a   = MSB_POS;
				phase_a = PH_HIGH;
				timer_a = first_word[23] ? at_least_one16(timing.one_high)
				                         : at_least_one16(timing.zero_high);
			end else begin
				phase_a = PH_GAP;
				timer_a = at_least_one20(timing.gap);
			end
		end

		level = phase_a == PH_HIGH;
		busy  = phase_a != PH_IDLE;

		timer_dec = (timer_a != '0) ? timer_a - TIMER_W'(1) : '0;
		bit_dn    = bit_a - 5'd1;
		cur_bit   = word_a[bit_a];
		nxt_bit   = word_a[bit_dn];
		ptr_inc   = ptr_a + CNT_W'(1);

		phase_n = phase_a;
		timer_n = timer_a;
		bit_n   = bit_a;
		word_n  = word_a;
		ptr_n   = ptr_a;
		cnt_n   = cnt_a;

		if (busy) begin
			timer_n = timer_dec;
			if (timer_dec == '0) begin
				unique case (phase_a)
					PH_HIGH: begin
						phase_n = PH_LOW;
						timer_n = cur_bit ? at_least_one16(timing.one_low)
						                  : at_least_one16(timing.zero_low);
					end
					PH_LOW: begin
						if (bit_a != 5'd0) begin
							bit_n   = bit_dn;
							phase_n = PH_HIGH;
							timer_n = nxt_bit ? at_least_one16(timing.one_high)
							                  : at_least_one16(timing.zero_high);
						end else begin
							ptr_n = ptr_inc;
							if (ptr_inc < cnt_a) begin
								word_n  = next_word;
								bit_n   = MSB_POS;
								phase_n = PH_HIGH;
								timer_n = next_word[23] ? at_least_one16(timing.one_high)
								                        : at_least_one16(timing.zero_high);
							end else begin
								phase_n = PH_GAP;
								timer_n = at_least_one20(timing.gap);
							end
						end
					end
					PH_GAP: begin
						phase_n = PH_IDLE;
						timer_n = '0;
					end
					default: begin
						phase_n = PH_IDLE;
						timer_n = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			bitpos_q    <= 5'd0;
			word_q      <= 24'd0;
			ptr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) out_valid_q <= item_valid;
			if (fire) begin
				phase_q  <= phase_n;
				timer_q  <= timer_n;
				bitpos_q <= bit_n;
				word_q   <= word_n;
				ptr_q    <= ptr_n;
				cnt_q    <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			line_level_q <= level;
			busy_res_q   <= busy;
			ignored_q    <= dropped;
		end
	end

	assign ptr        = ptr_q;
	assign out_valid  = out_valid_q;
	assign line_level = line_level_q;
	assign busy_res   = busy_res_q;
	assign ignored    = ignored_q;

	a_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> timer_q != '0)
		else $error("phase timer empty while sending");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HIGH || phase_q == PH_LOW) |-> ptr_q < cnt_q)
		else $error("pixel pointer past frame length while sending bits");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bitpos_q <= MSB_POS)
		else $error("bit position outside word");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> phase_q == PH_IDLE)
		else $error("buffer written while sending");

	a_drop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (ignored_q || line_level_q) |-> busy_res_q)
		else $error("dropped request or high line reported while not busy");

endmodule

// ===== design/rgb_pixel_chain_driver.sv =====
// Top level of the RGB pixel chain driver: configuration registers and stage wiring.
//
// Usage:
//   Each request on the input channel is one tick of the serial waveform. A request
//   carries an operation (tick only, write pixel, latch frame), a buffer slot, an
//   RRGGBB colour and a frame length. Every request yields exactly one result on the
//   output channel: the line level for that tick, the busy flag, and whether a write
//   or latch was dropped because a frame was still going out.
//   Configuration (gains, bit timings, gap length) is written on its own channel, which
//   is always ready; write it only while no requests are in flight.
// Pipeline and throughput:
//   A request passes four registers (input register, gain multiply, divide-by-255,
//   sequencer/result register). Unless out_ready stalls, one request per cycle is
//   taken and one result per cycle is given. The sequencer updates its state once per
//   request, so the buffer read for the next pixel is prefetched from the pointer and
//   corrected during the pixel being sent; slot zero keeps a corrected shadow copy.
// Reset:
//   arst_n clears all buffer fill bits at once (unwritten slots read as black), sets
//   gains to full scale and timings to their defaults, and empties the pipeline.
// Stalls:
//   When out_ready is low, the result register holds and earlier stages keep filling;
//   in_ready drops only once all four stages hold a request.
module rgb_pixel_chain_driver import rpcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  pixel_index,
	input  logic [23:0] colour,
	input  logic [15:0] frame_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        line_level,
	output logic        busy_res,
	output logic        ignored,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	gain_t            gains_q;
	timing_t          timing_q;
	logic             gain_upd;
	logic             item_valid, item_ready;
	item_t            item;
	pix_wr_t          wr;
	logic [CNT_W-1:0] ptr;
	logic [23:0]      first_word, next_word;

	// Accept configuration every cycle
	assign cfg_ready = 1'b1;

	assign gain_upd = cfg_valid && ((cfg_index == CFG_GAIN_RED) ||
	                                (cfg_index == CFG_GAIN_GREEN) ||
	                                (cfg_index == CFG_GAIN_BLUE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.red        <= 8'd255;
			gains_q.green      <= 8'd255;
			gains_q.blue       <= 8'd255;
			timing_q.one_high  <= 16'd140;
			timing_q.one_low   <= 16'd120;
			timing_q.zero_high <= 16'd70;
			timing_q.zero_low  <= 16'd160;
			timing_q.gap       <= 20'd10200;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GAIN_RED:   gains_q.red        <= cfg_data[7:0];
				CFG_GAIN_GREEN: gains_q.green      <= cfg_data[7:0];
				CFG_GAIN_BLUE:  gains_q.blue       <= cfg_data[7:0];
				CFG_ONE_HIGH:   timing_q.one_high  <= cfg_data[15:0];
				CFG_ONE_LOW:    timing_q.one_low   <= cfg_data[15:0];
				CFG_ZERO_HIGH:  timing_q.zero_high <= cfg_data[15:0];
				CFG_ZERO_LOW:   timing_q.zero_low  <= cfg_data[15:0];
				CFG_GAP:        timing_q.gap       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Register the request and correct its colour ahead of the sequencer
	rpcd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.pixel_index (pixel_index),
		.colour      (colour),
		.frame_count (frame_count),
		.gains       (gains_q),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item)
	);

	// Hold the pixels; keep slot zero and the upcoming pixel corrected and ready
	rpcd_pixbuf u_pixbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.gains      (gains_q),
		.gain_upd   (gain_upd),
		.wr         (wr),
		.rd_ptr     (ptr),
		.first_word (first_word),
		.next_word  (next_word)
	);

	// Advance the waveform one tick per request and drive the result
	rpcd_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.timing     (timing_q),
		.first_word (first_word),
		.next_word  (next_word),
		.wr         (wr),
		.ptr        (ptr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.line_level (line_level),
		.busy_res   (busy_res),
		.ignored    (ignored)
	);

endmodule
